@@ hw/rtl/miu_pkg.sv @@
// ----------------------------------------------------------------------------
// miu_pkg
// Types and constants shared by the modular inverse unit and its engine.
// ----------------------------------------------------------------------------
package miu_pkg;

   localparam int OPERAND_W = 63;
   localparam int MOD_W     = 31;
   // signed Bezout coefficient, magnitude bounded by the modulus
   localparam int COEF_W    = MOD_W + 2;
   localparam int SHIFT_W   = $clog2(MOD_W);
   localparam int CNT_W     = $clog2(OPERAND_W);

   localparam logic [MOD_W-1:0]   MODULUS_RESET = MOD_W'(1000000007);
   localparam logic [CNT_W-1:0]   REDUCE_LAST   = CNT_W'(OPERAND_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_ALIGN,
      ST_SUB,
      ST_FINISH
   } miu_state_type;

   typedef struct packed {
      logic idle;
      logic done;
   } miu_status_type;

endpackage

@@ hw/rtl/modular_inverse_unit_top.sv @@
// ----------------------------------------------------------------------------
// modular_inverse_unit_top
// Inverse of a 63-bit operand modulo a programmable 31-bit modulus.
//
//   Channel  Ports                                    Direction
//   request  req_valid, req_stall, req_operand        in (stall out)
//   response rsp_valid, rsp_stall, rsp_inverse,       out (stall in)
//            rsp_not_invertible
//   csr      csr_wr_en, csr_wr_data                   in
//
// A transaction is accepted only while the engine is idle. It reduces the operand
// (one bit a cycle), then works out each Euclid quotient by shift-and-subtract on
// one shared subtract/compare unit, then loads the output register. The next
// transaction is accepted from the cycle after the load; a stalled, full output
// register holds the engine.
// Synchronous reset restores the modulus to 1000000007 and idles the engine.
// A finished result waits in the output register while the next transaction
// is accepted and worked on.
// ----------------------------------------------------------------------------
module modular_inverse_unit_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [miu_pkg::OPERAND_W-1:0]  req_operand,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [miu_pkg::MOD_W-1:0]      rsp_inverse,
   output logic                           rsp_not_invertible,
   input  logic                           csr_wr_en,
   input  logic [miu_pkg::MOD_W-1:0]      csr_wr_data
);

   logic [miu_pkg::MOD_W-1:0]    modulus_ff, modulus_in;
   logic                         valid_ff, valid_in;
   logic [miu_pkg::MOD_W-1:0]    inverse_ff, inverse_in;
   logic                         flag_ff, flag_in;

   miu_pkg::miu_status_type      status;
   logic [miu_pkg::MOD_W-1:0]    eng_inverse;
   logic                         eng_not_invertible;
   logic                         start;
   logic                         take;

   assign start = req_valid && status.idle;
   // move a finished result into the output register once it is free
   assign take  = status.done && (!valid_ff || !rsp_stall);

   miu_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .ack            (take),
      .operand        (req_operand),
      .modulus        (modulus_ff),
      .status         (status),
      .inverse        (eng_inverse),
      .not_invertible (eng_not_invertible)
   );

   always_comb begin
      modulus_in = csr_wr_en ? csr_wr_data : modulus_ff;
      valid_in   = valid_ff;
      inverse_in = inverse_ff;
      flag_in    = flag_ff;
      if (take) begin
         valid_in   = 1'b1;
         inverse_in = eng_inverse;
         flag_in    = eng_not_invertible;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= miu_pkg::MODULUS_RESET;
         valid_ff   <= 1'b0;
      end else begin
         modulus_ff <= modulus_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inverse_ff <= inverse_in;
      flag_ff    <= flag_in;
   end

   assign req_stall          = !status.idle;
   assign rsp_valid          = valid_ff;
   assign rsp_inverse        = inverse_ff;
   assign rsp_not_invertible = flag_ff;

endmodule

@@ hw/rtl/miu_engine.sv @@
// ----------------------------------------------------------------------------
// miu_engine
// Sequencer and shared datapath: reduces the operand modulo the modulus one
// bit a cycle, then runs extended Euclid with shift-and-subtract quotients.
// ----------------------------------------------------------------------------
module miu_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           ack,
   input  logic [miu_pkg::OPERAND_W-1:0]  operand,
   input  logic [miu_pkg::MOD_W-1:0]      modulus,
   output miu_pkg::miu_status_type        status,
   output logic [miu_pkg::MOD_W-1:0]      inverse,
   output logic                           not_invertible
);

   miu_pkg::miu_state_type state_ff, state_in;

   logic [miu_pkg::OPERAND_W-1:0]       opnd_ff, opnd_in;
   logic [miu_pkg::MOD_W-1:0]           mod_ff, mod_in;
   logic [miu_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   logic [miu_pkg::MOD_W-1:0]           r0_ff, r0_in;
   logic [miu_pkg::MOD_W-1:0]           r1_ff, r1_in;
   logic [miu_pkg::MOD_W-1:0]           d_ff, d_in;
   logic [miu_pkg::SHIFT_W-1:0]         k_ff, k_in;
   logic signed [miu_pkg::COEF_W-1:0]   t0_ff, t0_in;
   logic signed [miu_pkg::COEF_W-1:0]   t1_ff, t1_in;
   logic signed [miu_pkg::COEF_W-1:0]   dt_ff, dt_in;

   // datapath terms
   logic [miu_pkg::MOD_W:0]             rem_sh;
   logic                                rem_ge;
   logic [miu_pkg::MOD_W-1:0]           rem_next;
   logic                                align_ok;
   logic                                sub_ge;
   logic [miu_pkg::MOD_W-1:0]           r0_sub;
   logic signed [miu_pkg::COEF_W-1:0]   t0_sub;
   logic signed [miu_pkg::COEF_W-1:0]   t0_wrap;

   assign rem_sh   = {r1_ff, opnd_ff[miu_pkg::OPERAND_W-1]};
   assign rem_ge   = rem_sh >= {1'b0, mod_ff};
   assign rem_next = rem_ge ? miu_pkg::MOD_W'(rem_sh - {1'b0, mod_ff})
                            : rem_sh[miu_pkg::MOD_W-1:0];
   assign align_ok = {d_ff, 1'b0} <= {1'b0, r0_ff};
   assign sub_ge   = d_ff <= r0_ff;
   assign r0_sub   = sub_ge ? (r0_ff - d_ff) : r0_ff;
   assign t0_sub   = sub_ge ? (t0_ff - dt_ff) : t0_ff;
   assign t0_wrap  = t0_ff + $signed({2'b00, mod_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         miu_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (modulus == '0) ? miu_pkg::ST_FINISH : miu_pkg::ST_REDUCE;
            end
         end
         miu_pkg::ST_REDUCE: begin
            if (cnt_ff == '0) begin
               state_in = (rem_next == '0) ? miu_pkg::ST_FINISH : miu_pkg::ST_ALIGN;
            end
         end
         miu_pkg::ST_ALIGN: begin
            if (!align_ok) begin
               state_in = miu_pkg::ST_SUB;
            end
         end
         miu_pkg::ST_SUB: begin
            if (k_ff == '0) begin
               state_in = (r0_sub == '0) ? miu_pkg::ST_FINISH : miu_pkg::ST_ALIGN;
            end
         end
         miu_pkg::ST_FINISH: begin
            if (ack) begin
               state_in = miu_pkg::ST_IDLE;
            end
         end
         default: state_in = miu_pkg::ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      opnd_in = opnd_ff;
      mod_in  = mod_ff;
      cnt_in  = cnt_ff;
      r0_in   = r0_ff;
      r1_in   = r1_ff;
      d_in    = d_ff;
      k_in    = k_ff;
      t0_in   = t0_ff;
      t1_in   = t1_ff;
      dt_in   = dt_ff;
      case (state_ff)
         miu_pkg::ST_IDLE: begin
            if (start) begin
               opnd_in = operand;
               mod_in  = modulus;
               cnt_in  = miu_pkg::REDUCE_LAST;
               r0_in   = modulus;
               r1_in   = '0;
               t0_in   = '0;
            end
         end
         miu_pkg::ST_REDUCE: begin
            // one restoring step of operand mod modulus
            opnd_in = {opnd_ff[miu_pkg::OPERAND_W-2:0], 1'b0};
            r1_in   = rem_next;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               r0_in = mod_ff;
               t0_in = '0;
               t1_in = miu_pkg::COEF_W'(1);
               d_in  = rem_next;
               dt_in = miu_pkg::COEF_W'(1);
               k_in  = '0;
            end
         end
         miu_pkg::ST_ALIGN: begin
            if (align_ok) begin
               d_in  = {d_ff[miu_pkg::MOD_W-2:0], 1'b0};
               dt_in = dt_ff <<< 1;
               k_in  = k_ff + 1'b1;
            end
         end
         miu_pkg::ST_SUB: begin
            if (k_ff == '0) begin
               // quotient complete: rotate remainders and coefficients
               r0_in = r1_ff;
               r1_in = r0_sub;
               t0_in = t1_ff;
               t1_in = t0_sub;
               d_in  = r0_sub;
               dt_in = t0_sub;
            end else begin
               r0_in = r0_sub;
               t0_in = t0_sub;
               d_in  = {1'b0, d_ff[miu_pkg::MOD_W-1:1]};
               dt_in = dt_ff >>> 1;
               k_in  = k_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      status.idle    = state_ff == miu_pkg::ST_IDLE;
      status.done    = state_ff == miu_pkg::ST_FINISH;
      not_invertible = r0_ff != miu_pkg::MOD_W'(1);
      if (not_invertible) begin
         inverse = '0;
      end else if (t0_ff < 0) begin
         inverse = t0_wrap[miu_pkg::MOD_W-1:0];
      end else begin
         inverse = t0_ff[miu_pkg::MOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= miu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
      mod_ff  <= mod_in;
      cnt_ff  <= cnt_in;
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      d_ff    <= d_in;
      k_ff    <= k_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      dt_ff   <= dt_in;
   end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for modular_inverse_unit_top. An extended Euclid
// predictor computes the inverse of every accepted operand under the current
// modulus, and each response is compared in order against that prediction.
// Directed operands cover the edge values under the reset modulus and under
// moduli of one, two, 2^31-1 and a composite. Random runs follow with random,
// large prime and smooth moduli, with random idle and stall bursts on both
// channels and a final stretch of back-to-back transactions.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int OPW = miu_pkg::OPERAND_W;
   localparam int MW  = miu_pkg::MOD_W;
   localparam logic [OPW-1:0] OPERAND_ALL_ONES = '1;
   localparam logic [MW-1:0]  MODULUS_ALL_ONES = '1;
   localparam logic [MW-1:0]  PRIME_1E9_9      = MW'(1000000009);

   typedef struct {
      logic [OPW-1:0] operand;
      logic [MW-1:0]  modulus;
      logic [MW-1:0]  inverse;
      logic           not_invertible;
   } inverse_expectation_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic [OPW-1:0]  req_operand = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic [MW-1:0]   rsp_inverse;
   logic            rsp_not_invertible;
   logic            csr_wr_en = 1'b0;
   logic [MW-1:0]   csr_wr_data = '0;

   inverse_expectation_type pending_inverses[$];
   logic [MW-1:0]   modulus_setting = miu_pkg::MODULUS_RESET;
   bit              req_idling = 1'b0;
   bit              rsp_idling = 1'b0;
   int unsigned     stall_left = 0;
   int unsigned     inverses_checked = 0;
   int unsigned     not_invertible_seen = 0;
   int unsigned     moduli_written = 0;
   int unsigned     mismatch_count = 0;

   modular_inverse_unit_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operand        (req_operand),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_inverse        (rsp_inverse),
      .rsp_not_invertible (rsp_not_invertible),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d inverses outstanding", pending_inverses.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Extended Euclid on the reduced operand; coefficient kept signed.
   function automatic inverse_expectation_type predict_inverse(
         input logic [OPW-1:0] operand, input logic [MW-1:0] modulus);
      inverse_expectation_type result;
      longint unsigned rem_prev, rem_cur, rem_next, quot;
      longint coef_prev, coef_cur, coef_next, mod_s;
      result.operand        = operand;
      result.modulus        = modulus;
      result.inverse        = '0;
      result.not_invertible = 1'b1;
      if (modulus == 0) return result;
      rem_prev  = longint'(modulus);
      rem_cur   = longint'(operand) % rem_prev;
      coef_prev = 0;
      coef_cur  = 1;
      while (rem_cur != 0) begin
         quot      = rem_prev / rem_cur;
         rem_next  = rem_prev - quot * rem_cur;
         rem_prev  = rem_cur;
         rem_cur   = rem_next;
         coef_next = coef_prev - longint'(quot) * coef_cur;
         coef_prev = coef_cur;
         coef_cur  = coef_next;
      end
      if (rem_prev != 1) return result;
      mod_s     = longint'(modulus);
      coef_prev = ((coef_prev % mod_s) + mod_s) % mod_s;
      result.inverse        = coef_prev[MW-1:0];
      result.not_invertible = 1'b0;
      return result;
   endfunction

   // Record each accepted operand, then compare each accepted response.
   always @(posedge clock) begin
      inverse_expectation_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_inverses.push_back(predict_inverse(req_operand, modulus_setting));
         if (rsp_valid && !rsp_stall) begin
            if (pending_inverses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected response inverse=%0d not_invertible=%0b",
                           $realtime, rsp_inverse, rsp_not_invertible);
            end else begin
               want = pending_inverses.pop_front();
               inverses_checked++;
               if (rsp_not_invertible) not_invertible_seen++;
               if (rsp_inverse !== want.inverse ||
                   rsp_not_invertible !== want.not_invertible) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: operand=%0d modulus=%0d expected %0d/%0b got %0d/%0b",
                              $realtime, want.operand, want.modulus, want.inverse,
                              want.not_invertible, rsp_inverse, rsp_not_invertible);
               end
            end
         end
      end
   end

   // Response back-pressure in random bursts.
   always @(posedge clock) begin
      if (stall_left == 0 && rsp_idling && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 17);
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_operand(input logic [OPW-1:0] operand);
      if (req_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_operand <= operand;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop the request and hold until every response is back; step the clock
   // before checking the queue so the last accepted transaction is already recorded.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_inverses.size() != 0) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [MW-1:0] value);
      drain;
      csr_wr_en       <= 1'b1;
      csr_wr_data     <= value;
      modulus_setting  = value;
      moduli_written++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [MW-1:0] random_modulus();
      longint m;
      case ($urandom_range(0, 4))
         0: m = PRIME_1E9_9;
         1: m = MODULUS_ALL_ONES;
         2: m = $urandom_range(1, 32'h7FFF_FFFF);
         3: m = $urandom_range(1, (32'd1 << $urandom_range(1, 31)) - 1);
         default: begin
            m = 1;
            repeat ($urandom_range(1, 24)) begin
               case ($urandom_range(0, 5))
                  0: if (m * 2 < 64'h8000_0000) m *= 2;
                  1: if (m * 3 < 64'h8000_0000) m *= 3;
                  2: if (m * 5 < 64'h8000_0000) m *= 5;
                  3: if (m * 7 < 64'h8000_0000) m *= 7;
                  4: if (m * 11 < 64'h8000_0000) m *= 11;
                  default: if (m * 13 < 64'h8000_0000) m *= 13;
               endcase
            end
         end
      endcase
      return m[MW-1:0];
   endfunction

   // Mix of full-width, narrow, near-multiple and factor-sharing operands.
   function automatic logic [OPW-1:0] random_operand(input logic [MW-1:0] modulus);
      logic [63:0] wide;
      logic [63:0] m;
      wide = {$urandom, $urandom};
      m    = 64'(modulus);
      case ($urandom_range(0, 5))
         0: return wide[OPW-1:0];
         1: return OPW'(wide >> $urandom_range(1, 63));
         2: return OPW'(m * $urandom + $urandom_range(0, 2));
         3: return OPW'(wide % m);
         4: return OPW'(64'($urandom_range(2, 13)) * (wide >> $urandom_range(4, 40)));
         default: return OPW'(m * $urandom_range(1, 5) - 64'($urandom_range(0, 1)));
      endcase
   endfunction

   task automatic run_random(input int unsigned moduli, input int unsigned per_modulus,
                             input bit smooth_only);
      logic [MW-1:0] m;
      repeat (moduli) begin
         m = random_modulus();
         if (smooth_only)
            while (m[0] && m % 3 != 0) m = random_modulus();
         write_modulus(m);
         repeat (per_modulus) send_operand(random_operand(m));
      end
   endtask

   task automatic test_reset_modulus;
      send_operand('0);
      send_operand(OPW'(1));
      send_operand(OPW'(2));
      send_operand(OPW'(1000000006));
      send_operand(OPW'(1000000007));
      send_operand(OPW'(2000000014));
      send_operand(OPW'(1000000008));
      send_operand(OPERAND_ALL_ONES);
      send_operand(OPW'(1) << (OPW - 1));
   endtask

   task automatic test_unit_modulus;
      write_modulus(MW'(1));
      send_operand('0);
      send_operand(OPERAND_ALL_ONES);
   endtask

   task automatic test_modulus_two;
      write_modulus(MW'(2));
      send_operand('0);
      send_operand(OPW'(1));
      send_operand(OPERAND_ALL_ONES);
      send_operand(OPW'(1) << (OPW - 1));
   endtask

   task automatic test_largest_modulus;
      write_modulus(MODULUS_ALL_ONES);
      send_operand(OPW'(MODULUS_ALL_ONES));
      send_operand(OPW'(MODULUS_ALL_ONES) - 1);
      send_operand(OPERAND_ALL_ONES);
      send_operand(OPW'(MODULUS_ALL_ONES) * 3 + 5);
   endtask

   task automatic test_composite_modulus;
      write_modulus(MW'(720720));
      send_operand(OPW'(360360));
      send_operand(OPW'(17));
      send_operand(OPW'(720719));
      send_operand(OPW'(105));
   endtask

   task automatic test_random_moduli;
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      run_random(10, 100, 1'b0);
   endtask

   task automatic test_shared_factors;
      run_random(4, 100, 1'b1);
   endtask

   task automatic test_back_to_back;
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      write_modulus(PRIME_1E9_9);
      repeat (175) send_operand(random_operand(PRIME_1E9_9));
      run_random(1, 175, 1'b0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_modulus;
      test_unit_modulus;
      test_modulus_two;
      test_largest_modulus;
      test_composite_modulus;
      test_random_moduli;
      test_shared_factors;
      test_back_to_back;
      drain;
      // allow any stray response to surface
      repeat (400) @(posedge clock);
      $display("checked %0d inverses (%0d not invertible) over %0d modulus settings",
               inverses_checked, not_invertible_seen, moduli_written + 1);
      $display("mismatches: %0d", mismatch_count);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
